// ===== hdl/rv64_integer_execute_unit_macros.svh =====
// Assertion macros shared by the checker.
`ifndef RV64_INTEGER_EXECUTE_UNIT_MACROS_SVH
`define RV64_INTEGER_EXECUTE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EXU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EXU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/exu_pkg.sv =====
package exu_pkg;

    localparam logic [4:0] K_ADD     = 5'd0;
    localparam logic [4:0] K_SUB     = 5'd1;
    localparam logic [4:0] K_SLL     = 5'd2;
    localparam logic [4:0] K_SLT     = 5'd3;
    localparam logic [4:0] K_SLTU    = 5'd4;
    localparam logic [4:0] K_XOR     = 5'd5;
    localparam logic [4:0] K_SRL     = 5'd6;
    localparam logic [4:0] K_SRA     = 5'd7;
    localparam logic [4:0] K_OR      = 5'd8;
    localparam logic [4:0] K_AND     = 5'd9;
    localparam logic [4:0] K_MUL     = 5'd10;
    localparam logic [4:0] K_DIV     = 5'd11;
    localparam logic [4:0] K_DIVU    = 5'd12;
    localparam logic [4:0] K_REM     = 5'd13;
    localparam logic [4:0] K_REMU    = 5'd14;
    localparam logic [4:0] K_SH1ADD  = 5'd15;
    localparam logic [4:0] K_SH2ADD  = 5'd16;
    localparam logic [4:0] K_SH3ADD  = 5'd17;
    localparam logic [4:0] K_SH1ADDU = 5'd18;
    localparam logic [4:0] K_SH2ADDU = 5'd19;
    localparam logic [4:0] K_ADDUW   = 5'd20;
    localparam logic [4:0] K_ADDW    = 5'd21;
    localparam logic [4:0] K_SRLW    = 5'd22;
    localparam logic [4:0] K_SRAW    = 5'd23;
    localparam logic [4:0] K_ZEXTH   = 5'd24;
    localparam logic [4:0] K_SEXTB   = 5'd25;
    localparam logic [4:0] K_SEXTH   = 5'd26;
    localparam logic [4:0] K_BSET    = 5'd27;
    localparam logic [4:0] K_BEXT    = 5'd28;

    localparam logic [1:0] CLS_ALU = 2'd0;
    localparam logic [1:0] CLS_MUL = 2'd1;
    localparam logic [1:0] CLS_DIV = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [4:0]  kind;
        logic [1:0]  cls;
        logic        bad;
        logic [63:0] a;
        logic [63:0] b;
    } exu_item_t;

endpackage

// ===== hdl/rv64_integer_execute_unit.sv =====
// A beat passes through the queue, the e1 stage and the output register to reach result.
// Throughput: one beat per cycle but for division and remainder, while rsp_stall is low.
// A division or remainder holds the execute stage in the shared radix-2 divider.
// A four-entry queue lets the front keep taking beats while the divider is busy.
// Reset is asynchronous and active low; it empties the queue and pipeline at once.
module rv64_integer_execute_unit #(
    parameter int XLEN_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [4:0]  kind,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [63:0] result,
    output logic        bad_kind
);
    import exu_pkg::*;

    exu_item_t push_item;
    exu_item_t head_item;
    logic      push;
    logic      pop;
    logic      full;
    logic      head_valid;

    exu_front #(
        .XLEN_BITS (XLEN_BITS)
    ) u_front (
        .req_valid  (req_valid),
        .kind       (kind),
        .operand_a  (operand_a),
        .operand_b  (operand_b),
        .queue_full (full),
        .push       (push),
        .item       (push_item)
    );

    exu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    exu_back #(
        .XLEN_BITS (XLEN_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .result     (result),
        .bad_kind   (bad_kind)
    );

    assign req_stall = full;

endmodule

// ===== hdl/exu_front.sv =====
module exu_front #(
    parameter int XLEN_BITS = 64
) (
    input  logic              req_valid,
    input  logic [4:0]        kind,
    input  logic [63:0]       operand_a,
    input  logic [63:0]       operand_b,
    input  logic              queue_full,
    output logic              push,
    output exu_pkg::exu_item_t item
);
    import exu_pkg::*;

    localparam logic [63:0] XMASK = 64'({64{1'b1}} >> (64 - XLEN_BITS));

    logic word_form;
    logic unknown;

    always_comb
    begin
        word_form = (kind inside {[K_SH1ADDU:K_SRAW]});
        unknown   = (kind > K_BEXT);
        item.kind = kind;
        item.a    = operand_a & XMASK;
        item.b    = operand_b & XMASK;
        item.bad  = unknown || (word_form && (XLEN_BITS < 64));
        if (item.bad)
        begin
            item.cls = CLS_ALU;
        end
        else if (kind == K_MUL)
        begin
            item.cls = CLS_MUL;
        end
        else if (kind inside {[K_DIV:K_REMU]})
        begin
            item.cls = CLS_DIV;
        end
        else
        begin
            item.cls = CLS_ALU;
        end
    end

    assign push = req_valid && !queue_full;

endmodule

// ===== hdl/exu_queue.sv =====
module exu_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  exu_pkg::exu_item_t push_item,
    input  logic               pop,
    output logic               full,
    output logic               head_valid,
    output exu_pkg::exu_item_t head_item
);
    import exu_pkg::*;

    exu_item_t            mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_next;
    logic [QUEUE_AW:0]    count_reg;
    logic [QUEUE_AW:0]    count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign full       = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

endmodule

// ===== hdl/exu_div.sv =====
module exu_div #(
    parameter int XLEN_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        ack,
    input  logic [4:0]  kind,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] res
);
    import exu_pkg::*;

    localparam logic [63:0] XMASK = 64'({64{1'b1}} >> (64 - XLEN_BITS));
    localparam logic [63:0] SIGN  = 64'(64'd1 << (XLEN_BITS - 1));

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic [5:0]  cnt_reg;
    logic [63:0] quo_reg;
    logic [64:0] rem_reg;
    logic [63:0] dvs_reg;
    logic [63:0] a_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic        want_rem_reg;
    logic        bzero_reg;
    logic [63:0] res_reg;

    logic        is_signed;
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [64:0] shifted;
    logic [64:0] diff;
    logic [63:0] mag_r;
    logic        neg_r;

    always_comb
    begin
        is_signed = (kind == K_DIV) || (kind == K_REM);
        mag_a     = (is_signed && ((a & SIGN) != '0)) ? ((64'd0 - a) & XMASK) : a;
        mag_b     = (is_signed && ((b & SIGN) != '0)) ? ((64'd0 - b) & XMASK) : b;
        shifted   = {rem_reg[63:0], quo_reg[63]};
        diff      = shifted - {1'b0, dvs_reg};
        mag_r     = want_rem_reg ? rem_reg[63:0] : quo_reg;
        neg_r     = want_rem_reg ? neg_r_reg : neg_q_reg;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: state_next = start ? ST_RUN : ST_IDLE;
            ST_RUN:  state_next = (cnt_reg == 6'd63) ? ST_FIN : ST_RUN;
            ST_FIN:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                end
                else if (ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cnt_reg      <= '0;
            quo_reg      <= mag_a;
            rem_reg      <= '0;
            dvs_reg      <= mag_b;
            a_reg        <= a;
            neg_q_reg    <= is_signed && (((a ^ b) & SIGN) != '0);
            neg_r_reg    <= is_signed && ((a & SIGN) != '0);
            want_rem_reg <= (kind == K_REM) || (kind == K_REMU);
            bzero_reg    <= (b == '0);
        end
        else if (state_reg == ST_RUN)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (!diff[64])
            begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
        if (state_reg == ST_FIN)
        begin
            if (bzero_reg)
            begin
                res_reg <= want_rem_reg ? a_reg : XMASK;
            end
            else
            begin
                res_reg <= neg_r ? ((64'd0 - mag_r) & XMASK) : mag_r;
            end
        end
    end

    assign done = (state_reg == ST_DONE);
    assign res  = res_reg;

endmodule

// ===== hdl/exu_back.sv =====
module exu_back #(
    parameter int XLEN_BITS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  exu_pkg::exu_item_t head_item,
    output logic               pop,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [63:0]        result,
    output logic               bad_kind
);
    import exu_pkg::*;

    localparam logic [63:0] XMASK   = 64'({64{1'b1}} >> (64 - XLEN_BITS));
    localparam logic [63:0] SIGN    = 64'(64'd1 << (XLEN_BITS - 1));
    localparam logic [5:0]  SH_MASK = 6'(XLEN_BITS - 1);

    logic        e1_valid_reg;
    logic        e1_valid_next;
    logic [1:0]  e1_cls_reg;
    logic        e1_bad_reg;
    logic [63:0] e1_res_reg;
    logic [63:0] e1_pp_lo_reg;
    logic [31:0] e1_pp_x_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] result_reg;
    logic        bad_reg;

    logic [63:0] a;
    logic [63:0] b;
    logic [5:0]  sh;
    logic [63:0] alu_val;
    logic [63:0] sum;
    logic [31:0] w32;
    logic [63:0] pp_lo;
    logic [31:0] pp_x;
    logic        out_free;
    logic        e1_done;
    logic        e1_move;
    logic        div_done;
    logic [63:0] div_res;

    always_comb
    begin
        a     = head_item.a;
        b     = head_item.b;
        sh    = b[5:0] & SH_MASK;
        sum   = a + b;
        w32   = '0;
        pp_lo = a[31:0] * b[31:0];
        pp_x  = 32'(a[31:0] * b[63:32]) + 32'(a[63:32] * b[31:0]);
        case (head_item.kind)
            K_ADD:     alu_val = sum;
            K_SUB:     alu_val = a - b;
            K_SLL:     alu_val = a << sh;
            K_SLT:     alu_val = {63'd0, (a ^ SIGN) < (b ^ SIGN)};
            K_SLTU:    alu_val = {63'd0, a < b};
            K_XOR:     alu_val = a ^ b;
            K_SRL:     alu_val = a >> sh;
            K_SRA:     alu_val = (a >> sh) | (((a & SIGN) != '0) ? ~(XMASK >> sh) : 64'd0);
            K_OR:      alu_val = a | b;
            K_AND:     alu_val = a & b;
            K_SH1ADD:  alu_val = b + (a << 1);
            K_SH2ADD:  alu_val = b + (a << 2);
            K_SH3ADD:  alu_val = b + (a << 3);
            K_SH1ADDU: alu_val = b + ({32'd0, a[31:0]} << 1);
            K_SH2ADDU: alu_val = b + ({32'd0, a[31:0]} << 2);
            K_ADDUW:   alu_val = b + {32'd0, a[31:0]};
            K_ADDW:    alu_val = {{32{sum[31]}}, sum[31:0]};
            K_SRLW:
            begin
                w32     = a[31:0] >> b[4:0];
                alu_val = {{32{w32[31]}}, w32};
            end
            K_SRAW:
            begin
                w32     = 32'($signed(a[31:0]) >>> b[4:0]);
                alu_val = {{32{w32[31]}}, w32};
            end
            K_ZEXTH:   alu_val = {48'd0, a[15:0]};
            K_SEXTB:   alu_val = {{56{a[7]}}, a[7:0]};
            K_SEXTH:   alu_val = {{48{a[15]}}, a[15:0]};
            K_BSET:    alu_val = a | (64'd1 << sh);
            K_BEXT:    alu_val = {63'd0, a[sh]};
            default:   alu_val = '0;
        endcase
    end

    assign out_free = !out_valid_reg || !rsp_stall;
    assign e1_done  = e1_valid_reg && ((e1_cls_reg != CLS_DIV) || div_done);
    assign e1_move  = e1_done && out_free;
    assign pop      = head_valid && (!e1_valid_reg || e1_move);

    always_comb
    begin
        e1_valid_next  = pop || (e1_valid_reg && !e1_move);
        out_valid_next = e1_move || (out_valid_reg && rsp_stall);
    end

    exu_div #(
        .XLEN_BITS (XLEN_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pop && (head_item.cls == CLS_DIV)),
        .ack   (e1_move && (e1_cls_reg == CLS_DIV)),
        .kind  (head_item.kind),
        .a     (a),
        .b     (b),
        .done  (div_done),
        .res   (div_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            e1_valid_reg  <= e1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e1_cls_reg   <= head_item.cls;
            e1_bad_reg   <= head_item.bad;
            e1_res_reg   <= head_item.bad ? 64'd0 : (alu_val & XMASK);
            e1_pp_lo_reg <= pp_lo;
            e1_pp_x_reg  <= pp_x;
        end
        if (e1_move)
        begin
            bad_reg <= e1_bad_reg;
            case (e1_cls_reg)
                CLS_MUL: result_reg <= (e1_pp_lo_reg + {e1_pp_x_reg, 32'd0}) & XMASK;
                CLS_DIV: result_reg <= div_res;
                default: result_reg <= e1_res_reg;
            endcase
        end
    end

    assign rsp_valid = out_valid_reg;
    assign result    = result_reg;
    assign bad_kind  = bad_reg;

endmodule

// ===== hdl/exu_checker.sv =====
`include "rv64_integer_execute_unit_macros.svh"

module exu_checker #(
    parameter int XLEN_BITS = 64
) (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic [4:0]  kind,
    input logic [63:0] operand_a,
    input logic [63:0] operand_b,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [63:0] result,
    input logic        bad_kind
);

    localparam logic [63:0] XMASK = 64'({64{1'b1}} >> (64 - XLEN_BITS));

    `EXU_ASSERT_NEXT(a_req_hold, req_valid && req_stall,
        req_valid && $stable(kind) && $stable(operand_a) && $stable(operand_b),
        "Request beat changed while stalled.")
    `EXU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "Response beat dropped while stalled.")
    `EXU_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(result) && $stable(bad_kind), "Response beat changed while stalled.")
    `EXU_ASSERT_SAME(a_bad_zero, rsp_valid && bad_kind, result == 64'd0, "Rejected kind gave a non-zero result.")
    `EXU_ASSERT_SAME(a_xlen_clean, rsp_valid, (result & ~XMASK) == 64'd0, "Result has bits set above the register width.")

endmodule

bind rv64_integer_execute_unit exu_checker #(.XLEN_BITS(XLEN_BITS)) u_exu_checker (.*);

// ===== sim/exu_checker.sv =====
`timescale 1ns / 100ps

module exu_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  logic [4:0]  kind,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic [63:0] result,
    input  logic        bad_kind,
    output int          errors,
    output int          pending
);
    import exu_pkg::*;

    typedef struct {
        logic [63:0] value;
        logic        bad;
    } exu_outcome_t;

    exu_outcome_t outcomes[$];

    function automatic logic [63:0] sext_from(logic [63:0] v, int bits);
        logic [63:0] m;
        logic [63:0] sb;
        m  = {64{1'b1}} >> (64 - bits);
        sb = 64'd1 << (bits - 1);
        return ((v & m) ^ sb) - sb;
    endfunction

    function automatic exu_outcome_t execute(logic [4:0] k, logic [63:0] a, logic [63:0] b);
        exu_outcome_t o;
        logic [5:0]   sh;
        logic [63:0]  aa;
        logic [63:0]  ab;
        logic [63:0]  au;
        sh = b[5:0];
        au = {32'd0, a[31:0]};
        aa = a[63] ? -a : a;
        ab = b[63] ? -b : b;
        o.value = '0;
        o.bad   = 1'b0;
        case (k)
            K_ADD:     o.value = a + b;
            K_SUB:     o.value = a - b;
            K_SLL:     o.value = a << sh;
            K_SLT:     o.value = {63'd0, $signed(a) < $signed(b)};
            K_SLTU:    o.value = {63'd0, a < b};
            K_XOR:     o.value = a ^ b;
            K_SRL:     o.value = a >> sh;
            K_SRA:     o.value = $signed(a) >>> sh;
            K_OR:      o.value = a | b;
            K_AND:     o.value = a & b;
            K_MUL:     o.value = a * b;
            K_DIV:
            begin
                if (b == 0)
                    o.value = '1;
                else
                begin
                    o.value = aa / ab;
                    if (a[63] ^ b[63])
                        o.value = -o.value;
                end
            end
            K_DIVU:    o.value = (b == 0) ? '1 : a / b;
            K_REM:
            begin
                if (b == 0)
                    o.value = a;
                else
                begin
                    o.value = aa % ab;
                    if (a[63])
                        o.value = -o.value;
                end
            end
            K_REMU:    o.value = (b == 0) ? a : a % b;
            K_SH1ADD:  o.value = b + (a << 1);
            K_SH2ADD:  o.value = b + (a << 2);
            K_SH3ADD:  o.value = b + (a << 3);
            K_SH1ADDU: o.value = b + (au << 1);
            K_SH2ADDU: o.value = b + (au << 2);
            K_ADDUW:   o.value = b + au;
            K_ADDW:    o.value = sext_from(a + b, 32);
            K_SRLW:    o.value = sext_from(au >> b[4:0], 32);
            K_SRAW:    o.value = sext_from(sext_from(a, 32) >> b[4:0], 32);
            K_ZEXTH:   o.value = {48'd0, a[15:0]};
            K_SEXTB:   o.value = sext_from(a, 8);
            K_SEXTH:   o.value = sext_from(a, 16);
            K_BSET:    o.value = a | (64'd1 << sh);
            K_BEXT:    o.value = {63'd0, a[sh]};
            default:   o.bad = 1'b1;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        exu_outcome_t w;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (outcomes.size() == 0)
                report_mismatch("unexpected beat", result, 64'd0);
            else
            begin
                w = outcomes.pop_front();
                if (result !== w.value)
                    report_mismatch("result", result, w.value);
                if (bad_kind !== w.bad)
                    report_mismatch("bad_kind", {63'd0, bad_kind}, {63'd0, w.bad});
            end
        end
        if (rst_n && req_valid && !req_stall)
            outcomes.push_back(execute(kind, operand_a, operand_b));
        pending = outcomes.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import exu_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [4:0]  kind = K_ADD;
    logic [63:0] operand_a = '0;
    logic [63:0] operand_b = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [63:0] result;
    logic        bad_kind;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          sent = 0;
    int          hold_cycles = 0;

    localparam int RANDOM_ITEMS = 1750;
    localparam int CYCLE_LIMIT  = 800000;

    always #2 clk = ~clk;

    rv64_integer_execute_unit dut (.*);

    exu_scoreboard scoreboard_i (.*);

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7fff_ffff_ffff_ffff;
            4: return 64'(signed'($urandom_range(0, 64)) - 32);
            5: return {32'd0, $urandom()};
            6: return 64'd1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 40)
            return 0;
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    task automatic send(logic [4:0] k, logic [63:0] a, logic [63:0] b);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        kind      <= k;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Stall the result side at random, with one long hold-off early in the random beats and a stall-free stretch later.
    always @(posedge clk)
    begin
        if (sent > 200 && sent < 230 && hold_cycles < 400)
        begin
            hold_cycles <= hold_cycles + 1;
            rsp_stall   <= 1'b1;
        end
        else if (sent > 1200 && sent < 1400)
            rsp_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 3)
            rsp_stall <= 1'b1;
        else if (rsp_stall && $urandom_range(0, 99) < 40)
            rsp_stall <= 1'b0;
        else if (!rsp_stall)
            rsp_stall <= $urandom_range(0, 99) < 20;
    end

    initial
    begin
        logic [63:0] corner[6];
        int          settle;
        corner = '{64'd0, 64'd1, '1, 64'h8000_0000_0000_0000,
                   64'h7fff_ffff_ffff_ffff, 64'h0000_0000_8000_0000};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < 32; k++)
            send(5'(k), corner[k % 6], corner[(k + 2) % 6]);
        send(K_DIV, 64'h8000_0000_0000_0000, '1);
        send(K_REM, 64'h8000_0000_0000_0000, '1);
        send(K_DIVU, 64'd77, 64'd0);
        send(K_REMU, 64'd77, 64'd0);
        send(K_REM, 64'hffff_ffff_ffff_fff9, 64'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            logic [4:0] k;
            if ($urandom_range(0, 99) < 5)
                k = 5'($urandom_range(K_DIV, K_REMU));
            else
                k = 5'($urandom_range(0, 31));
            send(k, pick_operand(), pick_operand());
        end
        req_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        settle = 0;
        while (settle < 200)
        begin
            @(posedge clk);
            settle++;
        end

        $display("Sent %0d beats over all 32 kind codes, with division corner cases,", sent);
        $display("random gaps and stalls, and a long result hold-off that filled the unit.");
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
